// File: rtl/linear_probing_hash_map_core_assert.svh
`ifndef LINEAR_PROBING_HASH_MAP_CORE_ASSERT_SVH
`define LINEAR_PROBING_HASH_MAP_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LPHM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LPHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lphm_pkg.sv
package lphm_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 3;
    localparam int OCC_W     = 11;
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = STAT_W;

    // home slot reduction: bits folded per cycle, steps per key
    localparam int HASH_BITS  = 4;
    localparam int HASH_STEPS = KEY_W / HASH_BITS;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_PUT    = 2'd0;
    localparam kind_t KIND_GET    = 2'd1;
    localparam kind_t KIND_REMOVE = 2'd2;

    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_EMPTY = 2'd0;
    localparam slot_t SLOT_LIVE  = 2'd1;
    localparam slot_t SLOT_TOMB  = 2'd2;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t STAT_INSERTED    = 3'd0;
    localparam status_t STAT_OVERWRITTEN = 3'd1;
    localparam status_t STAT_FOUND       = 3'd2;
    localparam status_t STAT_NOT_FOUND   = 3'd3;
    localparam status_t STAT_REMOVED     = 3'd4;
    localparam status_t STAT_FULL        = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RESP
    } state_t;

endpackage

// File: rtl/linear_probing_hash_map_core.sv
// Linear-probing key/value table, one request at a time.
// Request channel s_*: tuser = kind (0 put, 1 get, 2 remove), tdata = key, value.
// Result channel m_*: one item per request; tuser = status, tdata = read value
// and occupancy (live entries after the request).
// Steps per request: accept, hash, probe slots one by one, load the result
// register. The home slot is the low key bits when TABLE_SLOTS is a power of
// two, else key mod TABLE_SLOTS, folded 4 bits a cycle. Probe length is set by
// the single read port of the slot memories: slots are read in turn from the
// home slot until a hit or an empty slot; at most TABLE_SLOTS slots are read.
// Reset: status memory is swept to empty, one slot a cycle, over every slot;
// s_tready stays low until the sweep is done.
// Stall: the result register holds while m_tready is low; a new request is still
// taken and worked, and waits for the register before its result is shown.
module linear_probing_hash_map_core #(
    parameter int TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lphm_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] key, [63:32] value
    input  logic [lphm_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lphm_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] read_value, [42:32] occupancy
    output logic [lphm_pkg::M_TUSER_W-1:0] m_tuser   // [2:0] status
);
    import lphm_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int REM_W  = SLOT_W + 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int HCNT_W = $clog2(HASH_STEPS);
    localparam int KV_W   = KEY_W + VAL_W;
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [REM_W-1:0]  MOD       = REM_W'(TABLE_SLOTS);
    localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HASH_STEPS - 1);

    // slot memories
    slot_t             stat_mem [TABLE_SLOTS];
    logic [KV_W-1:0]   kv_mem   [TABLE_SLOTS];
    slot_t             stat_q_reg;
    logic [KV_W-1:0]   kv_q_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              stat_we;
    logic [SLOT_W-1:0] stat_wa;
    slot_t             stat_wd;
    logic              kv_we;
    logic [SLOT_W-1:0] kv_wa;
    logic [KV_W-1:0]   kv_wd;

    state_t state_reg, state_next;

    kind_t             kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [KEY_W-1:0]  hsh_sh_reg, hsh_sh_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [HCNT_W-1:0] hcnt_reg, hcnt_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [SLOT_W-1:0] chk_reg, chk_next;
    logic [SLOT_W-1:0] pass_reg, pass_next;
    logic              free_vld_reg, free_vld_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    status_t           res_stat_reg, res_stat_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;
    logic              m_tvalid_reg, m_tvalid_next;
    status_t           out_stat_reg, out_stat_next;
    logic [VAL_W-1:0]  out_val_reg, out_val_next;
    logic [OCC_W-1:0]  out_occ_reg, out_occ_next;

    logic              accept;
    logic [SLOT_W-1:0] rem_step;
    logic [SLOT_W-1:0] home;
    logic              hash_last;
    logic [SLOT_W-1:0] chk_inc;
    logic              slot_hit, slot_empty, slot_tomb, pass_last, probe_done;
    logic              eff_free_vld;
    logic [SLOT_W-1:0] eff_free;
    logic              out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // key mod TABLE_SLOTS, HASH_BITS bits a cycle from the top
    always_comb begin
        logic [SLOT_W-1:0] r;
        logic [REM_W-1:0]  t;
        r = rem_reg;
        for (int i = 0; i < HASH_BITS; i++) begin
            t = {r, hsh_sh_reg[KEY_W-1-i]};
            if (t >= MOD) begin
                t = t - MOD;
            end
            r = t[SLOT_W-1:0];
        end
        rem_step = r;
    end

    assign home      = IS_POW2 ? key_reg[SLOT_W-1:0] : rem_step;
    assign hash_last = IS_POW2 || (hcnt_reg == HCNT_LAST);

    assign chk_inc      = (chk_reg == LAST_SLOT) ? '0 : chk_reg + SLOT_W'(1);
    assign slot_empty   = (stat_q_reg == SLOT_EMPTY);
    assign slot_tomb    = (stat_q_reg == SLOT_TOMB);
    assign slot_hit     = (stat_q_reg == SLOT_LIVE) && (kv_q_reg[KEY_W-1:0] == key_reg);
    assign pass_last    = (pass_reg == LAST_SLOT);
    assign probe_done   = slot_hit || slot_empty || pass_last;
    assign eff_free_vld = free_vld_reg || slot_tomb;
    assign eff_free     = free_vld_reg ? free_reg : chk_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_last) begin
                    if (kind_reg == KIND_PUT || kind_reg == KIND_GET ||
                        kind_reg == KIND_REMOVE) begin
                        state_next = S_PROBE;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_PROBE: begin
                if (probe_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        kind_next     = kind_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        hsh_sh_next   = hsh_sh_reg;
        rem_next      = rem_reg;
        hcnt_next     = hcnt_reg;
        clr_next      = clr_reg;
        chk_next      = chk_reg;
        pass_next     = pass_reg;
        free_vld_next = free_vld_reg;
        free_next     = free_reg;
        cnt_next      = cnt_reg;
        res_stat_next = res_stat_reg;
        res_val_next  = res_val_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_stat_next = out_stat_reg;
        out_val_next  = out_val_reg;
        out_occ_next  = out_occ_reg;
        rd_addr       = chk_inc;
        stat_we       = 1'b0;
        stat_wa       = chk_reg;
        stat_wd       = SLOT_LIVE;
        kv_we         = 1'b0;
        kv_wa         = chk_reg;
        kv_wd         = {val_reg, key_reg};

        case (state_reg)
            S_CLEAR: begin
                stat_we  = 1'b1;
                stat_wa  = clr_reg;
                stat_wd  = SLOT_EMPTY;
                clr_next = clr_reg + SLOT_W'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    kind_next   = s_tuser;
                    key_next    = s_tdata[KEY_W-1:0];
                    val_next    = s_tdata[KEY_W+VAL_W-1:KEY_W];
                    hsh_sh_next = s_tdata[KEY_W-1:0];
                    rem_next    = '0;
                    hcnt_next   = '0;
                end
            end
            S_HASH: begin
                rem_next    = rem_step;
                hsh_sh_next = hsh_sh_reg << HASH_BITS;
                hcnt_next   = hcnt_reg + HCNT_W'(1);
                rd_addr     = home;
                chk_next    = home;
                pass_next   = '0;
                free_vld_next = 1'b0;
                res_stat_next = STAT_NOT_FOUND;
                res_val_next  = '0;
            end
            S_PROBE: begin
                chk_next  = chk_inc;
                pass_next = pass_reg + SLOT_W'(1);
                case (kind_reg)
                    KIND_PUT: begin
                        free_vld_next = eff_free_vld;
                        free_next     = eff_free;
                        if (slot_hit) begin
                            kv_we         = 1'b1;
                            res_stat_next = STAT_OVERWRITTEN;
                        end else if (slot_empty || pass_last) begin
                            if (slot_empty || eff_free_vld) begin
                                stat_we       = 1'b1;
                                stat_wa       = eff_free;
                                kv_we         = 1'b1;
                                kv_wa         = eff_free;
                                cnt_next      = cnt_reg + CNT_W'(1);
                                res_stat_next = STAT_INSERTED;
                            end else begin
                                res_stat_next = STAT_FULL;
                            end
                        end
                    end
                    KIND_GET: begin
                        if (slot_hit) begin
                            res_stat_next = STAT_FOUND;
                            res_val_next  = kv_q_reg[KV_W-1:KEY_W];
                        end
                    end
                    KIND_REMOVE: begin
                        if (slot_hit) begin
                            stat_we       = 1'b1;
                            stat_wd       = SLOT_TOMB;
                            kv_we         = 1'b1;
                            kv_wd         = {{VAL_W{1'b0}}, key_reg};
                            cnt_next      = cnt_reg - CNT_W'(1);
                            res_stat_next = STAT_REMOVED;
                        end
                    end
                    default: begin
                        res_stat_next = STAT_NOT_FOUND;
                    end
                endcase
            end
            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_stat_next = res_stat_reg;
                    out_val_next  = res_val_reg;
                    out_occ_next  = OCC_W'(cnt_reg);
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    // writes land before the next request's first read, so no forwarding needed
    always_ff @(posedge aclk) begin
        if (stat_we) begin
            stat_mem[stat_wa] <= stat_wd;
        end
        stat_q_reg <= stat_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (kv_we) begin
            kv_mem[kv_wa] <= kv_wd;
        end
        kv_q_reg <= kv_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            free_vld_reg <= 1'b0;
            hcnt_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            free_vld_reg <= free_vld_next;
            hcnt_reg     <= hcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        hsh_sh_reg   <= hsh_sh_next;
        rem_reg      <= rem_next;
        chk_reg      <= chk_next;
        pass_reg     <= pass_next;
        free_reg     <= free_next;
        res_stat_reg <= res_stat_next;
        res_val_reg  <= res_val_next;
        out_stat_reg <= out_stat_next;
        out_val_reg  <= out_val_next;
        out_occ_reg  <= out_occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {{(M_TDATA_W - OCC_W - VAL_W){1'b0}}, out_occ_reg, out_val_reg};

endmodule

// File: rtl/lphm_checker.sv
`include "linear_probing_hash_map_core_assert.svh"

module lphm_checker #(
    parameter int TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lphm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lphm_pkg::M_TUSER_W-1:0] m_tuser
);
    import lphm_pkg::*;

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(TABLE_SLOTS);
    localparam bit OCC_FITS = TABLE_SLOTS < (1 << OCC_W);

    logic [VAL_W-1:0]               rd_val;
    logic [OCC_W-1:0]               occ;
    logic [M_TUSER_W+M_TDATA_W-1:0] out_bus;
    logic                           out_stall;
    logic                           out_miss;
    logic                           out_full;
    logic                           occ_chk;
    logic                           in_accept;

    assign rd_val    = m_tdata[VAL_W-1:0];
    assign occ       = m_tdata[VAL_W+OCC_W-1:VAL_W];
    assign out_bus   = {m_tuser, m_tdata};
    assign out_stall = m_tvalid && !m_tready;
    assign out_miss  = m_tvalid && (m_tuser != STAT_FOUND);
    assign out_full  = m_tvalid && (m_tuser == STAT_FULL);
    assign occ_chk   = m_tvalid && OCC_FITS;
    assign in_accept = s_tvalid && s_tready;

    `LPHM_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, $stable(out_bus), "stalled result moved")
    `LPHM_ASSERT_NOW(a_val_only_found, aclk, aresetn, out_miss, rd_val == '0, "value without a hit")
    `LPHM_ASSERT_NOW(a_full_occ, aclk, aresetn, out_full, occ == OCC_FULL, "full with free slots")
    `LPHM_ASSERT_NOW(a_occ_bound, aclk, aresetn, occ_chk, occ <= OCC_FULL, "occupancy too high")
    `LPHM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_accept, !s_tready, "accepted while busy")

endmodule

bind linear_probing_hash_map_core lphm_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
) u_lphm_checker (.*);
